### design/dbbc_pkg.sv
package dbbc_pkg;

  localparam int CoefCount = 24;
  localparam int CoefIdxW  = 5;
  localparam int CfgAddrW  = 5;

  // highest coefficient index that a load may write
  localparam logic [CoefIdxW-1:0] CoefLast = CoefIdxW'(CoefCount - 1);

  // register byte addresses
  localparam logic [CfgAddrW-1:0] AddrInvFocalX = 5'd0;
  localparam logic [CfgAddrW-1:0] AddrInvFocalY = 5'd4;
  localparam logic [CfgAddrW-1:0] AddrCenterX   = 5'd8;
  localparam logic [CfgAddrW-1:0] AddrCenterY   = 5'd12;
  localparam logic [CfgAddrW-1:0] AddrInvScale  = 5'd16;
  localparam logic [CfgAddrW-1:0] AddrDepthLim  = 5'd20;
  localparam logic [CfgAddrW-1:0] AddrBoxHalf   = 5'd24;

  localparam logic signed [31:0] CoefOne = 32'sd65536;

  // round to nearest, ties away from zero, shift by n
  function automatic logic signed [95:0] rnd_shift(input logic signed [95:0] v,
                                                    input int n);
    logic [95:0] m;
    logic neg;
    begin
      neg = v[95];
      m   = neg ? 96'(-v) : 96'(v);
      m   = (m + (96'd1 << (n - 1))) >> n;
      rnd_shift = neg ? -$signed(m) : $signed(m);
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
    begin
      if (v > 96'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -96'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] coef_reset(input int i);
    begin
      if (i == 0 || i == 4 || i == 8 || i == 12 || i == 16 || i == 20) coef_reset = CoefOne;
      else coef_reset = '0;
    end
  endfunction

endpackage

### design/depth_backproject_box_classify.sv
// Throughput: one item per cycle; pipeline advances whenever output is free.
// Stages: depth scale, keep test, normalize, camera point, rotate products, sum/classify.
// Reset: asynchronous active low; configuration registers take their reset values, transform
// coefficients become identity rotations with zero translations, pipe empties.
module depth_backproject_box_classify (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [dbbc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [11:0] pixel_col_i,
  input  logic [11:0] pixel_row_i,
  input  logic [15:0] raw_depth_i,
  input  logic [dbbc_pkg::CoefIdxW-1:0] coef_index_i,
  input  logic signed [31:0] coef_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        point_valid_o,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic signed [31:0] world_z_o,
  output logic        in_box_o
);

  logic [31:0] inv_fx_q, inv_fy_q, inv_sc_q;
  logic [15:0] cx_q, cy_q;
  logic [30:0] lim_q, half_q;
  logic signed [31:0] coef_q [dbbc_pkg::CoefCount];

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign pready     = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_fx_q <= 32'd8589934;
      inv_fy_q <= 32'd8589934;
      cx_q     <= 16'd5112;
      cy_q     <= 16'd3832;
      inv_sc_q <= 32'd858993;
      lim_q    <= 31'd393216;
      half_q   <= 31'd20972;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        dbbc_pkg::AddrInvFocalX: inv_fx_q <= pwdata;
        dbbc_pkg::AddrInvFocalY: inv_fy_q <= pwdata;
        dbbc_pkg::AddrCenterX:   cx_q     <= pwdata[15:0];
        dbbc_pkg::AddrCenterY:   cy_q     <= pwdata[15:0];
        dbbc_pkg::AddrInvScale:  inv_sc_q <= pwdata;
        dbbc_pkg::AddrDepthLim:  lim_q    <= pwdata[30:0];
        dbbc_pkg::AddrBoxHalf:   half_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      dbbc_pkg::AddrInvFocalX: prdata = inv_fx_q;
      dbbc_pkg::AddrInvFocalY: prdata = inv_fy_q;
      dbbc_pkg::AddrCenterX:   prdata = {16'd0, cx_q};
      dbbc_pkg::AddrCenterY:   prdata = {16'd0, cy_q};
      dbbc_pkg::AddrInvScale:  prdata = inv_sc_q;
      dbbc_pkg::AddrDepthLim:  prdata = {1'b0, lim_q};
      dbbc_pkg::AddrBoxHalf:   prdata = {1'b0, half_q};
      default:                 prdata = '0;
    endcase
  end

  // stage 1: depth scale
  logic        v1_q, p1_q, l1_q;
  logic [47:0] zr1_q;
  logic [11:0] u1_q, r1_q;
  logic [dbbc_pkg::CoefIdxW-1:0] i1_q;
  logic signed [31:0] c1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q  <= !func_i;
      l1_q  <= func_i;
      i1_q  <= coef_index_i;
      c1_q  <= coef_value_i;
      zr1_q <= 48'(raw_depth_i) * 48'(inv_sc_q);
      u1_q  <= pixel_col_i;
      r1_q  <= pixel_row_i;
    end
  end

  // stage 2: keep test and pixel offsets
  logic [32:0] zu2;
  logic        keep2;
  assign zu2   = 33'((zr1_q + 48'h8000) >> 16);
  assign keep2 = p1_q && zu2 != '0 && !(lim_q != '0 && zu2 > {2'b0, lim_q});
  logic        v2_q, k2_q, l2_q;
  logic [30:0] z2_q;
  logic signed [17:0] du2_q, dv2_q;
  logic [dbbc_pkg::CoefIdxW-1:0] i2_q;
  logic signed [31:0] c2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      k2_q  <= keep2;
      l2_q  <= l1_q;
      i2_q  <= i1_q;
      c2_q  <= c1_q;
      z2_q  <= zu2 > 33'h7fffffff ? 31'h7fffffff : zu2[30:0];
      du2_q <= $signed({2'b0, u1_q, 4'b0}) - $signed({2'b0, cx_q});
      dv2_q <= $signed({2'b0, r1_q, 4'b0}) - $signed({2'b0, cy_q});
    end
  end

  // stage 3: normalized coordinates
  logic v3_q, k3_q, l3_q;
  logic [30:0] z3_q;
  logic signed [31:0] nx3_q, ny3_q;
  logic [dbbc_pkg::CoefIdxW-1:0] i3_q;
  logic signed [31:0] c3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      k3_q  <= k2_q;
      l3_q  <= l2_q;
      i3_q  <= i2_q;
      c3_q  <= c2_q;
      z3_q  <= z2_q;
      nx3_q <= 32'(dbbc_pkg::rnd_shift(96'(50'(du2_q) * 50'($signed({1'b0, inv_fx_q}))), 20));
      ny3_q <= 32'(dbbc_pkg::rnd_shift(96'(50'(dv2_q) * 50'($signed({1'b0, inv_fy_q}))), 20));
    end
  end

  // stage 4: camera point
  logic v4_q, k4_q, l4_q;
  logic signed [31:0] cam4_q [3];
  logic [dbbc_pkg::CoefIdxW-1:0] i4_q;
  logic signed [31:0] c4_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      k4_q      <= k3_q;
      l4_q      <= l3_q;
      i4_q      <= i3_q;
      c4_q      <= c3_q;
      cam4_q[0] <= dbbc_pkg::sat32(dbbc_pkg::rnd_shift(
                     96'(64'(nx3_q) * 64'($signed({1'b0, z3_q}))), 16));
      cam4_q[1] <= dbbc_pkg::sat32(dbbc_pkg::rnd_shift(
                     96'(64'(ny3_q) * 64'($signed({1'b0, z3_q}))), 16));
      cam4_q[2] <= $signed({1'b0, z3_q});
    end
  end

  // coefficient loads commit as they leave stage 4: older pixels further down
  // still see the old set, younger pixels behind see the new one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dbbc_pkg::CoefCount; i++) coef_q[i] <= dbbc_pkg::coef_reset(i);
    end else if (adv && v4_q && l4_q && i4_q <= dbbc_pkg::CoefLast) begin
      coef_q[i4_q] <= c4_q;
    end
  end

  // stage 5: rotation products, rounded
  logic v5_q, k5_q;
  logic signed [47:0] pr5_q [18];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      k5_q <= k4_q;
      for (int t = 0; t < 2; t++)
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            pr5_q[t*9 + r*3 + c] <= 48'(dbbc_pkg::rnd_shift(
              96'(64'(coef_q[t*12 + r*3 + c]) * 64'(cam4_q[c])), 16));
    end
  end

  // stage 6: sums, saturation and box test into output register
  logic signed [49:0] wsum [3];
  logic signed [49:0] bsum [3];
  logic box_hit;
  always_comb begin
    box_hit = 1'b1;
    for (int r = 0; r < 3; r++) begin
      wsum[r] = 50'(coef_q[9 + r]) + 50'(pr5_q[r*3]) + 50'(pr5_q[r*3+1]) + 50'(pr5_q[r*3+2]);
      bsum[r] = 50'(coef_q[21 + r]) + 50'(pr5_q[9+r*3]) + 50'(pr5_q[9+r*3+1])
              + 50'(pr5_q[9+r*3+2]);
      if (bsum[r] > $signed({19'd0, half_q}) || bsum[r] < -$signed({19'd0, half_q}))
        box_hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      point_valid_o <= k5_q;
      world_x_o     <= k5_q ? dbbc_pkg::sat32(96'(wsum[0])) : '0;
      world_y_o     <= k5_q ? dbbc_pkg::sat32(96'(wsum[1])) : '0;
      world_z_o     <= k5_q ? dbbc_pkg::sat32(96'(wsum[2])) : '0;
      in_box_o      <= k5_q && box_hit;
    end
  end

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(world_x_o))
    else $error("result changed under stall");
  // flags only on kept points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_valid_o |-> !in_box_o && world_x_o == 0)
    else $error("flag on dropped point");
  // stall reaches input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken under stall");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct packed {
    logic              point_valid;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic              in_box;
  } point_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_stall_o;
  logic        func_i;
  logic [11:0] pixel_col_i, pixel_row_i;
  logic [15:0] raw_depth_i;
  logic [4:0]  coef_index_i;
  logic signed [31:0] coef_value_i;
  logic        out_valid_o, out_stall_i;
  logic        point_valid_o, in_box_o;
  logic signed [31:0] world_x_o, world_y_o, world_z_o;

  depth_backproject_box_classify u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .func_i, .pixel_col_i, .pixel_row_i, .raw_depth_i,
    .coef_index_i, .coef_value_i, .out_valid_o, .out_stall_i, .point_valid_o,
    .world_x_o, .world_y_o, .world_z_o, .in_box_o
  );

  // shadow copy of the block's registers and coefficients
  logic [31:0] m_inv_fx, m_inv_fy, m_inv_scale;
  logic [15:0] m_cx, m_cy;
  logic [30:0] m_dlim, m_half;
  logic signed [31:0] m_coef [dbbc_pkg::CoefCount];

  point_t expected_points[$];
  int     errors;
  int     idle_cycles;
  bit     hold_off;
  bit     in_burst;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint round_div(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 << (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cam_axis(logic [11:0] pix, logic [15:0] ctr, logic [31:0] inv_f,
                                      longint z);
    longint du, nrm;
    du  = longint'({pix, 4'd0}) - longint'(ctr);
    nrm = round_div(du * longint'({32'd0, inv_f}), 20);
    return clamp32(round_div(nrm * z, 16));
  endfunction

  // mirror the block: returns the expected point and applies loads
  function automatic point_t project_pixel(logic fn, logic [11:0] col, logic [11:0] row,
                                           logic [15:0] raw, logic [4:0] idx,
                                           logic signed [31:0] val);
    point_t p;
    longint zu, cam[3], wld[3], rel[3], a;
    bit box_hit;
    p = '0;
    if (fn) begin
      if (idx < dbbc_pkg::CoefCount) m_coef[idx] = val;
      return p;
    end
    zu = (longint'(raw) * longint'({32'd0, m_inv_scale}) + 32768) >>> 16;
    if (zu == 0) return p;
    if (m_dlim != 0 && zu > longint'(m_dlim)) return p;
    if (zu > 64'sd2147483647) zu = 64'sd2147483647;
    cam[0] = cam_axis(col, m_cx, m_inv_fx, zu);
    cam[1] = cam_axis(row, m_cy, m_inv_fy, zu);
    cam[2] = zu;
    for (int r = 0; r < 3; r++) begin
      wld[r] = longint'(m_coef[9 + r]);
      rel[r] = longint'(m_coef[21 + r]);
      for (int c = 0; c < 3; c++) begin
        wld[r] += round_div(longint'(m_coef[r * 3 + c]) * cam[c], 16);
        rel[r] += round_div(longint'(m_coef[12 + r * 3 + c]) * cam[c], 16);
      end
    end
    box_hit = 1'b1;
    for (int r = 0; r < 3; r++) begin
      a = (rel[r] < 0) ? -rel[r] : rel[r];
      if (a > longint'(m_half)) box_hit = 1'b0;
    end
    p.point_valid = 1'b1;
    p.wx = 32'(clamp32(wld[0]));
    p.wy = 32'(clamp32(wld[1]));
    p.wz = 32'(clamp32(wld[2]));
    p.in_box = box_hit;
    return p;
  endfunction

  task automatic write_reg(logic [4:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      dbbc_pkg::AddrInvFocalX: m_inv_fx = data;
      dbbc_pkg::AddrInvFocalY: m_inv_fy = data;
      dbbc_pkg::AddrCenterX:   m_cx = data[15:0];
      dbbc_pkg::AddrCenterY:   m_cy = data[15:0];
      dbbc_pkg::AddrInvScale:  m_inv_scale = data;
      dbbc_pkg::AddrDepthLim:  m_dlim = data[30:0];
      dbbc_pkg::AddrBoxHalf:   m_half = data[30:0];
      default: ;
    endcase
  endtask

  // drain the pipe before touching registers
  task automatic wait_idle();
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // offer one item; a random gap may open between bursts
  task automatic send_item(logic fn, logic [11:0] col, logic [11:0] row, logic [15:0] raw,
                           logic [4:0] idx, logic signed [31:0] val);
    point_t exp_item;
    if (!in_burst && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_burst = ($urandom_range(0, 9) != 0);
    in_valid_i <= 1'b1;
    func_i <= fn; pixel_col_i <= col; pixel_row_i <= row; raw_depth_i <= raw;
    coef_index_i <= idx; coef_value_i <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_item = project_pixel(fn, col, row, raw, idx, val);
    expected_points = {expected_points, exp_item};
  endtask

  task automatic end_stream();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [11:0] col, logic [11:0] row, logic [15:0] raw);
    send_item(1'b0, col, row, raw, 5'($urandom), $urandom);
  endtask

  task automatic send_load(logic [4:0] idx, logic signed [31:0] val);
    send_item(1'b1, 12'($urandom), 12'($urandom), 16'($urandom), idx, val);
  endtask

  task automatic test_directed();
    send_pixel(12'd320, 12'd240, 16'd5000);
    send_pixel(12'd0, 12'd0, 16'd1);
    send_pixel(12'hfff, 12'hfff, 16'd0);
    send_pixel(12'hfff, 12'd0, 16'hffff);
    send_pixel(12'd0, 12'hfff, 16'd30000);
    send_pixel(12'd319, 12'd239, 16'd100);
    send_load(5'd24, 32'sh7fffffff);
    send_load(5'd31, 32'sh80000000);
    send_load(5'd9, 32'sh00010000);
    send_load(5'd21, -32'sd65536);
    send_pixel(12'd320, 12'd240, 16'd4000);
    send_load(5'd9, 32'sd0);
    send_load(5'd21, 32'sd0);
    end_stream();
    wait_idle();
    // limit off, huge scale: saturating depth and world values
    write_reg(dbbc_pkg::AddrDepthLim, 32'd0);
    write_reg(dbbc_pkg::AddrInvScale, 32'hffffffff);
    write_reg(dbbc_pkg::AddrBoxHalf, 32'hffffffff);
    write_reg(dbbc_pkg::AddrInvFocalX, 32'hffffffff);
    write_reg(dbbc_pkg::AddrInvFocalY, 32'd0);
    write_reg(dbbc_pkg::AddrCenterX, 32'hffffffff);
    write_reg(dbbc_pkg::AddrCenterY, 32'd0);
    send_pixel(12'hfff, 12'hfff, 16'hffff);
    send_pixel(12'd0, 12'd0, 16'hffff);
    send_pixel(12'd1, 12'd2, 16'd1);
    send_load(5'd0, 32'sh7fffffff);
    send_load(5'd4, 32'sh80000000);
    send_pixel(12'd0, 12'hfff, 16'hffff);
    send_pixel(12'hfff, 12'd7, 16'd2);
    end_stream();
    wait_idle();
  endtask

  task automatic random_config();
    write_reg(dbbc_pkg::AddrInvFocalX,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 25));
    write_reg(dbbc_pkg::AddrInvFocalY,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 25));
    write_reg(dbbc_pkg::AddrCenterX, $urandom);
    write_reg(dbbc_pkg::AddrCenterY, $urandom);
    write_reg(dbbc_pkg::AddrInvScale,
              $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22));
    write_reg(dbbc_pkg::AddrDepthLim, $urandom_range(0, 2) == 0 ? 32'd0 : $urandom);
    write_reg(dbbc_pkg::AddrBoxHalf,
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18));
  endtask

  task automatic random_item();
    logic signed [31:0] cv;
    if ($urandom_range(0, 5) == 0) begin
      cv = ($urandom_range(0, 1)) ? $signed($urandom) : $signed($urandom_range(0, 131072)) - 65536;
      send_load(5'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 23)), cv);
    end else begin
      send_pixel(12'($urandom), 12'($urandom),
                 $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 2)) : 16'($urandom));
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      random_config();
      for (int k = 0; k < 200; k++) random_item();
      end_stream();
      wait_idle();
    end
  endtask

  // receiver holds off while pixels keep coming
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 250; k++) random_item();
    join
    end_stream();
    wait_idle();
  endtask

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= hold_off || ($urandom_range(0, 7) < 2 && ($urandom_range(0, 1) == 0));
    end
  end

  // compare each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    point_t got, exp_p;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {point_valid_o, world_x_o, world_y_o, world_z_o, in_box_o};
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected transfer %h", $realtime, got);
        errors++;
      end else begin
        exp_p = expected_points.pop_front();
        if (got !== exp_p) begin
          $display("%0t: mismatch expected pv=%0b x=%0d y=%0d z=%0d box=%0b",
                   $realtime, exp_p.point_valid, exp_p.wx, exp_p.wy, exp_p.wz, exp_p.in_box);
          $display("%0t:          actual   pv=%0b x=%0d y=%0d z=%0d box=%0b",
                   $realtime, got.point_valid, got.wx, got.wy, got.wz, got.in_box);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    errors = 0; idle_cycles = 0; hold_off = 1'b0; in_burst = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; func_i = 1'b0; pixel_col_i = '0; pixel_row_i = '0;
    raw_depth_i = '0; coef_index_i = '0; coef_value_i = '0;
    m_inv_fx = 32'd8589934; m_inv_fy = 32'd8589934; m_cx = 16'd5112; m_cy = 16'd3832;
    m_inv_scale = 32'd858993; m_dlim = 31'd393216; m_half = 31'd20972;
    for (int i = 0; i < dbbc_pkg::CoefCount; i++) m_coef[i] = 32'sd0;
    m_coef[0] = dbbc_pkg::CoefOne; m_coef[4] = dbbc_pkg::CoefOne;
    m_coef[8] = dbbc_pkg::CoefOne; m_coef[12] = dbbc_pkg::CoefOne;
    m_coef[16] = dbbc_pkg::CoefOne; m_coef[20] = dbbc_pkg::CoefOne;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_points.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
